@@ src/rbsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Buffer slot pool package
// Shared field widths, request and status codes, register indexes and the
// record that travels along the row of slot cells.
// ----------------------------------------------------------------------------
package rbsp_pkg;

   localparam int OPCODE_BITS = 2;
   localparam int SLOT_BITS   = 4;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_OUT_BITS = 8;
   localparam int CSR_DATA_BITS = 5;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_DATA_BITS-1:0] MIN_SLOTS_RESET = 5'd0;
   localparam logic [CSR_DATA_BITS-1:0] MAX_SLOTS_RESET = 5'd16;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_FIND    = 2'd0,
      OP_ACQUIRE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_RELEASE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_GROWN     = 2'd1,
      ST_NONE      = 2'd2,
      ST_REL_ZERO  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_SLOTS = 1'd0,
      CSR_MAX_SLOTS = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic                      found;
      logic                      hit;
      logic                      rel_zero;
      logic [SLOT_BITS-1:0]      slot;
      logic [COUNT_OUT_BITS-1:0] count;
   } chain_type;

endpackage

@@ src/rbsp_if.sv @@
// ----------------------------------------------------------------------------
// Buffer slot pool channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbsp_req_if;
   import rbsp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [SLOT_BITS-1:0]   slot_index;
   modport source (output valid, output opcode, output slot_index, input ready);
   modport sink (input valid, input opcode, input slot_index, output ready);
endinterface

interface rbsp_rsp_if;
   import rbsp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_BITS-1:0]    status;
   logic [SLOT_BITS-1:0]      slot;
   logic [COUNT_OUT_BITS-1:0] ref_count;
   modport source (output valid, output status, output slot, output ref_count, input ready);
   modport sink (input valid, input status, input slot, input ref_count, output ready);
endinterface

interface rbsp_csr_if;
   import rbsp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/rbsp_cell.sv @@
// ----------------------------------------------------------------------------
// Buffer slot pool cell
// Holds the reference count of one slot, takes part in the lowest-free search
// and merges its answer into the record passed along the row.
// ----------------------------------------------------------------------------
module rbsp_cell #(
   parameter int IDX        = 0,
   parameter int COUNT_BITS = 8,
   parameter int CMP_BITS   = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  rbsp_pkg::opcode_type       opcode,
   input  logic [CMP_BITS-1:0]        req_idx,
   input  logic [CMP_BITS-1:0]        live,
   input  logic                       grow,
   input  rbsp_pkg::chain_type        chain_in,
   output rbsp_pkg::chain_type        chain_out
);
   import rbsp_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;
   localparam logic [CMP_BITS-1:0]  IDX_C   = CMP_BITS'(IDX);
   localparam logic [SLOT_BITS-1:0] SLOT_LO = SLOT_BITS'(IDX);

   logic [COUNT_BITS-1:0] count_ff, count_in, count_after;
   logic [WIDE_BITS-1:0]  count_wide;
   logic                  live_here, zero, addr, find_hit, hit;

   always_comb begin
      live_here = IDX_C < live;
      zero      = count_ff == '0;
      addr      = (opcode != OP_FIND) && live_here && (req_idx == IDX_C);
      find_hit  = (opcode == OP_FIND) && live_here && zero && !chain_in.found;
      hit       = addr || find_hit;

      case (opcode)
         OP_ACQUIRE: count_after = (count_ff == '1) ? count_ff : count_ff + 1'b1;
         OP_RELEASE: count_after = zero ? count_ff : count_ff - 1'b1;
         default:    count_after = count_ff;
      endcase
      count_wide = WIDE_BITS'(count_after);

      count_in = count_ff;
      if (accept && addr) begin
         count_in = count_after;
      end else if (accept && grow && (IDX_C == live)) begin
         count_in = '0;
      end

      chain_out.found    = chain_in.found || (live_here && zero);
      chain_out.hit      = chain_in.hit || hit;
      chain_out.rel_zero = chain_in.rel_zero || (addr && (opcode == OP_RELEASE) && zero);
      chain_out.slot     = chain_in.slot | (hit ? SLOT_LO : '0);
      chain_out.count    = chain_in.count | (hit ? count_wide[COUNT_OUT_BITS-1:0] : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ src/refcounted_buffer_slot_pool.sv @@
// ----------------------------------------------------------------------------
// Reference-counted buffer slot pool
// Response: a request's response is registered in the cycle after it is taken.
// Throughput: one request per cycle, stalled while a response waits; the row
// of slot cells resolves lowest-free search and count update in the same cycle.
// Reset clears slot counts and grown count, min_slots to 0, max_slots to 16.
// ----------------------------------------------------------------------------
module refcounted_buffer_slot_pool #(
   parameter int POOL_SLOTS = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   rbsp_req_if.sink   req,
   rbsp_rsp_if.source rsp,
   rbsp_csr_if.sink   csr
);
   import rbsp_pkg::*;

   localparam int LIVE_BITS = $clog2(POOL_SLOTS + 1);
   localparam int CMP_BITS  = (LIVE_BITS > CSR_DATA_BITS) ? LIVE_BITS : CSR_DATA_BITS;
   localparam logic [CMP_BITS-1:0] POOL_C = CMP_BITS'(POOL_SLOTS);

   logic [CSR_DATA_BITS-1:0]  min_slots_ff, min_slots_in;
   logic [CSR_DATA_BITS-1:0]  max_slots_ff, max_slots_in;
   logic [CMP_BITS-1:0]       grown_ff, grown_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]    status_ff, status_in;
   logic [SLOT_BITS-1:0]      slot_ff, slot_in;
   logic [COUNT_OUT_BITS-1:0] count_ff, count_in;

   logic [CMP_BITS-1:0] min_c, max_c, live, lim, req_idx;
   logic                accept, grow;
   opcode_type          opcode;
   chain_type           chain [POOL_SLOTS+1];

   assign csr.ready = 1'b1;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign opcode    = opcode_type'(req.opcode);
   assign req_idx   = CMP_BITS'(req.slot_index);

   always_comb begin
      min_c = CMP_BITS'(min_slots_ff);
      max_c = CMP_BITS'(max_slots_ff);
      if (min_c > POOL_C) begin
         min_c = POOL_C;
      end
      lim = (max_c > POOL_C) ? POOL_C : max_c;
      live = (grown_ff > min_c) ? grown_ff : min_c;
   end

   assign chain[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < POOL_SLOTS; gi++) begin : g_cell
         rbsp_cell #(
            .IDX        (gi),
            .COUNT_BITS (COUNT_BITS),
            .CMP_BITS   (CMP_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .accept    (accept),
            .opcode    (opcode),
            .req_idx   (req_idx),
            .live      (live),
            .grow      (grow),
            .chain_in  (chain[gi]),
            .chain_out (chain[gi+1])
         );
      end
   endgenerate

   assign grow = (opcode == OP_FIND) && !chain[POOL_SLOTS].found && (live < lim);

   always_comb begin
      min_slots_in = min_slots_ff;
      max_slots_in = max_slots_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_MIN_SLOTS: min_slots_in = csr.data;
            CSR_MAX_SLOTS: max_slots_in = csr.data;
            default:       min_slots_in = min_slots_ff;
         endcase
      end

      grown_in = grown_ff;
      if (accept && grow) begin
         grown_in = live + 1'b1;
      end

      status_in = status_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      if (accept) begin
         slot_in  = chain[POOL_SLOTS].slot;
         count_in = chain[POOL_SLOTS].count;
         if (chain[POOL_SLOTS].hit) begin
            status_in = chain[POOL_SLOTS].rel_zero ? ST_REL_ZERO : ST_OK;
         end else if (grow) begin
            status_in = ST_GROWN;
            slot_in   = live[SLOT_BITS-1:0];
            count_in  = '0;
         end else begin
            status_in = ST_NONE;
         end
      end

      rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_slots_ff <= MIN_SLOTS_RESET;
         max_slots_ff <= MAX_SLOTS_RESET;
         grown_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_slots_ff <= min_slots_in;
         max_slots_ff <= max_slots_in;
         grown_ff     <= grown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      count_ff  <= count_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.slot      = slot_ff;
   assign rsp.ref_count = count_ff;

endmodule
